// File: rtl/tmpm_pkg.sv
// ----------------------------------------------------------------------------
// tmpm_pkg
// Shared codes for the trie multi-pattern matcher.
// ----------------------------------------------------------------------------
package tmpm_pkg;
  localparam logic [1:0] FUNC_PATTERN = 2'd0;
  localparam logic [1:0] FUNC_TEXT    = 2'd1;
  localparam logic [1:0] FUNC_CLEAR   = 2'd2;
  localparam logic [1:0] FUNC_NONE    = 2'd3;

  localparam logic [1:0] ST_MATCH = 2'd0;
  localparam logic [1:0] ST_EOT   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] V_IDLE = 2'd0;
  localparam logic [1:0] V_PEND = 2'd1;
  localparam logic [1:0] V_HIT  = 2'd2;
  localparam logic [1:0] V_MISS = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] position;
    logic        last_of_run;
  } result_t;
endpackage

// File: rtl/trie_multi_pattern_match.sv
// ----------------------------------------------------------------------------
// trie_multi_pattern_match
// Builds a DNA trie from pattern symbols and reports text positions at which
// a stored pattern (a leaf) is reached.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata                         tuser
// s_axis   in   [1:0] func, [3:2] symbol      -        tlast = last
// m_axis   out  [1:0] status, [33:2] position -        tlast = last_of_run
//
// Pattern symbol: the child row is read, then the edge is followed or a new
// node linked; a full-trie result holds the input until taken.
// Text symbol: each queued walk slot is visited in turn, and a pending walk
// reads its row and misses or advances (its new row is read for the leaf
// check); a root edge starts a new walk with its own leaf check; pending
// walks abort on the last symbol; finished slots are released, matches sent.
// One child table read port serves every walk in turn. Clear sweeps MAX_NODES
// rows, one per cycle, as does the clearing pass after reset. The input is not
// ready while an item is in work or a result waits.
// ----------------------------------------------------------------------------
module trie_multi_pattern_match
  import tmpm_pkg::*;
#(
  parameter int MAX_NODES       = 1024,
  parameter int MAX_PATTERN_LEN = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] func, [3:2] symbol
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [1:0] status, [33:2] position
  output logic        m_axis_tlast
);
  localparam int NW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int SW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int CW = NW + 1;
  localparam int DW = $clog2(MAX_PATTERN_LEN + 1);
  localparam logic [CW-1:0] NODES_MAX = CW'(MAX_NODES);
  localparam logic [SW-1:0] SLOT_LAST = SW'(MAX_PATTERN_LEN - 1);
  localparam logic [DW-1:0] PLEN = DW'(MAX_PATTERN_LEN);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_PRD   = 4'd2;
  localparam logic [3:0] S_PDEC  = 4'd3;
  localparam logic [3:0] S_WRD   = 4'd4;
  localparam logic [3:0] S_WDEC  = 4'd5;
  localparam logic [3:0] S_LRD   = 4'd6;
  localparam logic [3:0] S_LDEC  = 4'd7;
  localparam logic [3:0] S_REL   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_EOT   = 4'd10;
  localparam logic [3:0] S_ABORT = 4'd11;

  // child table memory: one row of four child ids per node
  logic [4*NW-1:0] mem [MAX_NODES];
  logic [4*NW-1:0] rd_data;
  logic [NW-1:0]   rd_addr;
  logic            wr_en;
  logic [NW-1:0]   wr_addr;
  logic [4*NW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  logic [3:0]    state;
  logic [CW-1:0] node_count;
  logic [NW-1:0] build_cursor;
  logic [DW-1:0] build_depth;
  logic          skip_rest;
  logic [NW-1:0] walk_node [MAX_PATTERN_LEN];
  logic [1:0]    walk_verdict [MAX_PATTERN_LEN];
  logic [SW-1:0] walk_head;
  logic [DW-1:0] walk_queued;
  logic [31:0]   text_counter;
  logic [NW-1:0] clr_idx;
  logic [SW-1:0] slot;
  logic [DW-1:0] scan_cnt;
  logic [NW-1:0] nx_hold;
  logic [SW-1:0] new_slot;
  logic [1:0]    func;
  logic [1:0]    sym;
  logic          last;
  logic          out_valid;
  result_t       out_r;
  logic [NW-1:0] child;

  assign s_axis_tready = (state == S_IDLE) && !out_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_r.position, out_r.status};
  assign m_axis_tlast  = out_r.last_of_run;
  assign child = rd_data[sym*NW +: NW];

  always_comb begin
    rd_addr = '0;
    case (state)
      S_IDLE:  rd_addr = '0;
      S_PRD:   rd_addr = build_cursor;
      // past the queued walks the root row is read for a new walk
      S_WRD:   rd_addr = (scan_cnt == walk_queued) ? '0 : walk_node[slot];
      S_LRD:   rd_addr = nx_hold;
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = build_cursor;
    wr_data = rd_data;
    if (state == S_CLR) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx;
      wr_data = '0;
    end else if (state == S_PDEC && !skip_rest && build_depth < PLEN
                 && child == '0 && node_count < NODES_MAX) begin
      wr_en = 1'b1;
      wr_data[sym*NW +: NW] = node_count[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_idx      <= '0;
      func         <= FUNC_PATTERN;
      node_count   <= CW'(1);
      build_cursor <= '0;
      build_depth  <= '0;
      skip_rest    <= 1'b0;
      walk_head    <= '0;
      walk_queued  <= '0;
      text_counter <= '0;
      out_valid    <= 1'b0;
      for (int i = 0; i < MAX_PATTERN_LEN; i++) walk_verdict[i] <= V_IDLE;
    end else begin
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          if (clr_idx == NW'(MAX_NODES - 1)) begin
            clr_idx <= '0;
            state   <= (func == FUNC_CLEAR) ? S_ABORT : S_IDLE;
          end else begin
            clr_idx <= clr_idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid && !out_valid) begin
            func    <= s_axis_tdata[1:0];
            sym     <= s_axis_tdata[3:2];
            last    <= s_axis_tlast;
            case (s_axis_tdata[1:0])
              FUNC_PATTERN: state <= S_PRD;
              FUNC_TEXT: begin
                slot     <= walk_head;
                scan_cnt <= '0;
                state    <= S_WRD;
              end
              FUNC_CLEAR: begin
                node_count   <= CW'(1);
                build_cursor <= '0;
                build_depth  <= '0;
                skip_rest    <= 1'b0;
                clr_idx      <= '0;
                state        <= S_CLR;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_PRD: state <= S_PDEC;
        S_PDEC: begin
          state <= S_IDLE;
          if (skip_rest) begin
            if (last) begin
              skip_rest    <= 1'b0;
              build_cursor <= '0;
              build_depth  <= '0;
            end
          end else if (build_depth < PLEN && child != '0) begin
            build_cursor <= last ? '0 : child;
            build_depth  <= last ? '0 : build_depth + 1'b1;
          end else if (build_depth < PLEN && node_count < NODES_MAX) begin
            build_cursor <= last ? '0 : node_count[NW-1:0];
            node_count   <= node_count + 1'b1;
            build_depth  <= last ? '0 : build_depth + 1'b1;
          end else begin
            out_r     <= '{status: ST_FULL, position: 32'd0, last_of_run: 1'b1};
            out_valid <= 1'b1;
            if (last) begin
              build_cursor <= '0;
              build_depth  <= '0;
            end else begin
              skip_rest <= 1'b1;
            end
          end
        end
        // advance each pending walk over the shared read port
        S_WRD: begin
          if (scan_cnt == walk_queued) begin
            new_slot <= slot;
            state    <= S_LDEC;
          end else if (walk_verdict[slot] == V_PEND) begin
            state <= S_WDEC;
          end else begin
            slot     <= (slot == SLOT_LAST) ? '0 : slot + 1'b1;
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        S_WDEC: begin
          if (child == '0) begin
            walk_verdict[slot] <= V_MISS;
            slot     <= (slot == SLOT_LAST) ? '0 : slot + 1'b1;
            scan_cnt <= scan_cnt + 1'b1;
            state    <= S_WRD;
          end else begin
            walk_node[slot] <= child;
            nx_hold         <= child;
            state           <= S_LRD;
          end
        end
        S_LRD: state <= S_LDEC;
        S_LDEC: begin
          if (scan_cnt < walk_queued) begin
            // leaf check of an advanced walk
            if (rd_data == '0) walk_verdict[slot] <= V_HIT;
            slot     <= (slot == SLOT_LAST) ? '0 : slot + 1'b1;
            scan_cnt <= scan_cnt + 1'b1;
            state    <= S_WRD;
          end else if (scan_cnt == walk_queued) begin
            // rd_data holds the root row here
            text_counter <= text_counter + 1'b1;
            if (walk_queued < PLEN && child != '0) begin
              walk_node[new_slot] <= child;
              nx_hold             <= child;
              scan_cnt            <= scan_cnt + 1'b1;
              state               <= S_LRD;
            end else begin
              if (walk_queued < PLEN) begin
                walk_verdict[new_slot] <= V_IDLE;
                walk_queued            <= walk_queued + 1'b1;
              end
              state <= last ? S_ABORT : S_REL;
            end
          end else begin
            // leaf check of the walk started at this position
            walk_verdict[new_slot] <= (rd_data == '0) ? V_HIT : V_PEND;
            walk_queued <= walk_queued + 1'b1;
            state       <= last ? S_ABORT : S_REL;
          end
        end
        S_ABORT: begin
          for (int i = 0; i < MAX_PATTERN_LEN; i++)
            if (walk_verdict[i] == V_PEND) walk_verdict[i] <= V_MISS;
          state <= S_REL;
        end
        S_REL: begin
          if (!out_valid || m_axis_tready) begin
            if (walk_queued != '0 && walk_verdict[walk_head] != V_PEND) begin
              walk_verdict[walk_head] <= V_IDLE;
              walk_head   <= (walk_head == SLOT_LAST) ? '0 : walk_head + 1'b1;
              walk_queued <= walk_queued - 1'b1;
              if (walk_verdict[walk_head] == V_HIT) begin
                out_r.status      <= ST_MATCH;
                out_r.position    <= text_counter - 32'(walk_queued);
                out_r.last_of_run <= 1'b0;
                state             <= S_OUT;
              end
            end else begin
              state <= S_EOT;
            end
          end
        end
        S_OUT: begin
          // hold the match until we know whether another result follows
          if (walk_queued != '0 && walk_verdict[walk_head] != V_PEND &&
              (walk_verdict[walk_head] == V_IDLE ||
               walk_verdict[walk_head] == V_MISS)) begin
            walk_verdict[walk_head] <= V_IDLE;
            walk_head   <= (walk_head == SLOT_LAST) ? '0 : walk_head + 1'b1;
            walk_queued <= walk_queued - 1'b1;
          end else begin
            out_r.last_of_run <= !(walk_queued != '0 &&
                                   walk_verdict[walk_head] == V_HIT) &&
                                 !(func == FUNC_TEXT && last);
            out_valid <= 1'b1;
            state     <= S_REL;
          end
        end
        S_EOT: begin
          if (func == FUNC_TEXT && last) begin
            if (!out_valid) begin
              out_r     <= '{status: ST_EOT, position: text_counter,
                             last_of_run: 1'b1};
              out_valid    <= 1'b1;
              text_counter <= '0;
              state        <= S_IDLE;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
